FILE: hdl/best_fit_region_allocator_unit_defines.svh
// Assertion macros for the best-fit region allocator.
`ifndef BEST_FIT_REGION_ALLOCATOR_UNIT_DEFINES_SVH
`define BEST_FIT_REGION_ALLOCATOR_UNIT_DEFINES_SVH

// check sampled on clk, off while rst is high
`define BFRA_CHK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bfra check failed");

// check sampled on clk, live during reset as well
`define BFRA_CHK_NR(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("bfra check failed");

`endif

FILE: hdl/bfra_pkg.sv
// Package: constants, types and codes of the best-fit region allocator.
`default_nettype none
package bfra_pkg;

  localparam int REGION_MAX_BYTES = 65536;
  localparam int PAGE_BYTES       = 4096;
  localparam int MAX_SEGMENTS     = 64;

  localparam int GRAN      = 8;
  localparam int GRAN_SH   = 3;
  localparam int TAG_DEPTH = REGION_MAX_BYTES / GRAN;
  localparam int GW        = $clog2(TAG_DEPTH);      // granule index
  localparam int LW        = GW + 1;                  // length in granules
  localparam int NCELL     = MAX_SEGMENTS + 1;
  localparam int IDX_W     = $clog2(NCELL);
  localparam int CNT_W     = $clog2(NCELL + 1);
  localparam int REQ_W     = 17;
  localparam int ADDR_W    = 16;
  localparam int CFG_W     = 17;
  localparam int NEED_W    = REQ_W - GRAN_SH + 1;
  localparam int PAGE_SH   = $clog2(PAGE_BYTES);
  localparam int PG_W      = CFG_W + 1 - PAGE_SH;
  localparam int MAX_PAGES = REGION_MAX_BYTES / PAGE_BYTES;
  localparam int MAX_GRAN  = TAG_DEPTH;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BADADDR = 2'd2;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [2:0] {
    OP_HOLD   = 3'd0,
    OP_INIT   = 3'd1,
    OP_INSERT = 3'd2,
    OP_MERGE  = 3'd3,
    OP_SHRINK = 3'd4,
    OP_DELETE = 3'd5
  } cell_op_t;

  typedef struct packed {
    logic          v;
    logic [GW-1:0] st;
    logic [LW-1:0] ln;
  } seg_t;

  typedef struct packed {
    logic             found;
    logic [LW-1:0]    ln;
    logic [GW-1:0]    st;
    logic [IDX_W-1:0] idx;
  } tok_t;

  typedef struct packed {
    cell_op_t         op;
    logic [GW-1:0]    key_st;
    logic [LW-1:0]    key_ln;
    logic [NEED_W-1:0] need;
    logic [IDX_W-1:0] sel;
    logic [LW-1:0]    init_ln;
  } ctl_t;

  typedef struct packed {
    logic any_touch;
    logic key_adj;
    tok_t best;
  } chain_stat_t;

endpackage
`default_nettype wire

FILE: hdl/bfra_if.sv
// Channel interfaces: request, response and region configuration.
`default_nettype none
interface bfra_req_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [bfra_pkg::REQ_W-1:0] req_size;
  logic [bfra_pkg::ADDR_W-1:0] free_addr;
  logic                       merge_adjacent;
  modport source (output valid, kind, req_size, free_addr, merge_adjacent, input ready);
  modport sink (input valid, kind, req_size, free_addr, merge_adjacent, output ready);
endinterface

interface bfra_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [bfra_pkg::ADDR_W-1:0] block_addr;
  modport source (output valid, status, block_addr, input ready);
  modport sink (input valid, status, block_addr, output ready);
endinterface

interface bfra_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [bfra_pkg::CFG_W-1:0] region_bytes;
  modport source (output valid, region_bytes, input ready);
  modport sink (input valid, region_bytes, output ready);
endinterface
`default_nettype wire

FILE: hdl/bfra_cell.sv
// One free-segment cell: holds a segment, shifts with its neighbors, forwards the fit token.
`default_nettype none
module bfra_cell (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire bfra_pkg::ctl_t             ctl,
  input  wire logic [bfra_pkg::IDX_W-1:0] idx,
  input  wire bfra_pkg::seg_t             left,
  input  wire logic                       left_ge,
  input  wire bfra_pkg::seg_t             right,
  input  wire logic                       pre_in,
  input  wire bfra_pkg::tok_t             tok_in,
  output bfra_pkg::seg_t                  seg,
  output logic                            ge,
  output logic                            pre_out,
  output logic                            adj,
  output bfra_pkg::tok_t                  tok
);
  import bfra_pkg::*;

  seg_t          seg_next;
  tok_t          tok_next;
  logic [LW-1:0] seg_end;
  logic [LW-1:0] key_end;
  logic          touch;
  logic          fits;
  logic          better;

  assign seg_end = {1'b0, seg.st} + seg.ln;
  assign key_end = {1'b0, ctl.key_st} + ctl.key_ln;
  assign touch   = seg.v && right.v && (seg_end == {1'b0, right.st});
  assign ge      = !seg.v || (seg.st >= ctl.key_st);
  assign pre_out = pre_in | touch;
  assign adj     = seg.v && ((seg_end == {1'b0, ctl.key_st}) || ({1'b0, seg.st} == key_end));
  assign fits    = seg.v && ({1'b0, seg.ln} >= ctl.need);
  assign better  = fits && (!tok_in.found || (seg.ln < tok_in.ln));

  always_comb begin
    seg_next = seg;
    case (ctl.op)
      OP_INIT: begin
        seg_next.v  = (idx == '0) && (ctl.init_ln != '0);
        seg_next.st = '0;
        seg_next.ln = ctl.init_ln;
      end
      OP_INSERT: begin
        if (left_ge) begin
          seg_next = left;
        end else if (ge) begin
          seg_next = '{v: 1'b1, st: ctl.key_st, ln: ctl.key_ln};
        end
      end
      OP_MERGE: begin
        if (pre_in) begin
          seg_next = right;
        end else if (touch) begin
          seg_next.ln = seg.ln + right.ln;
        end
      end
      OP_SHRINK: begin
        if (idx == ctl.sel) begin
          seg_next.st = seg.st + ctl.need[GW-1:0];
          seg_next.ln = seg.ln - ctl.need[LW-1:0];
        end
      end
      OP_DELETE: begin
        if (idx >= ctl.sel) begin
          seg_next = right;
        end
      end
      default: seg_next = seg;
    endcase
  end

  always_comb begin
    tok_next = tok_in;
    if (better) begin
      tok_next = '{found: 1'b1, ln: seg.ln, st: seg.st, idx: idx};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg.v     <= 1'b0;
      tok.found <= 1'b0;
    end else begin
      seg.v     <= seg_next.v;
      tok.found <= tok_next.found;
    end
    seg.st  <= seg_next.st;
    seg.ln  <= seg_next.ln;
    tok.ln  <= tok_next.ln;
    tok.st  <= tok_next.st;
    tok.idx <= tok_next.idx;
  end

endmodule
`default_nettype wire

FILE: hdl/bfra_chain.sv
// Row of segment cells in address order, with the merge and fit chains between them.
`default_nettype none
module bfra_chain (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire bfra_pkg::ctl_t        ctl,
  output bfra_pkg::chain_stat_t      stat
);
  import bfra_pkg::*;

  seg_t             seg_w   [NCELL];
  seg_t             left_w  [NCELL];
  seg_t             right_w [NCELL];
  tok_t             tok_w   [NCELL];
  tok_t             tin_w   [NCELL];
  logic [NCELL-1:0] ge_w;
  logic [NCELL-1:0] lge_w;
  logic [NCELL-1:0] adj_w;
  logic [NCELL:0]   pre_w;

  assign pre_w[0] = 1'b0;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_w[i] = '0;
      assign lge_w[i]  = 1'b0;
      assign tin_w[i]  = '0;
    end else begin : g_mid
      assign left_w[i] = seg_w[i-1];
      assign lge_w[i]  = ge_w[i-1];
      assign tin_w[i]  = tok_w[i-1];
    end
    if (i == NCELL - 1) begin : g_last
      assign right_w[i] = '0;
    end else begin : g_inner
      assign right_w[i] = seg_w[i+1];
    end

    bfra_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .idx     (IDX_W'(i)),
      .left    (left_w[i]),
      .left_ge (lge_w[i]),
      .right   (right_w[i]),
      .pre_in  (pre_w[i]),
      .tok_in  (tin_w[i]),
      .seg     (seg_w[i]),
      .ge      (ge_w[i]),
      .pre_out (pre_w[i+1]),
      .adj     (adj_w[i]),
      .tok     (tok_w[i])
    );
  end

  assign stat.any_touch = pre_w[NCELL];
  assign stat.key_adj   = |adj_w;
  assign stat.best      = tok_w[NCELL-1];

endmodule
`default_nettype wire

FILE: hdl/best_fit_region_allocator_unit.sv
// Top level: request sequencer, block tag memory and the segment cell row.
//
//   channel  dir  payload
//   req      in   kind, req_size, free_addr, merge_adjacent
//   rsp      out  status, block_addr
//   cfg      in   region_bytes
//
// Allocate: S_SEARCH while the fit token crosses all 65 cells, then S_APPLY and S_DONE.
// Free: S_TAGRD, S_FDEC, S_DONE; with merging, S_MERGE before S_DONE, once per merge performed
// and once more. Null or misaligned address: straight to S_DONE. A held rsp word keeps S_DONE waiting.
// After rst or a cfg word all 8192 tag memory entries are swept clear; req waits.
// One item at a time; a finished word sits in the rsp register while the next is taken.
`include "best_fit_region_allocator_unit_defines.svh"
`default_nettype none
module best_fit_region_allocator_unit (
  input  wire logic clk,
  input  wire logic rst,
  bfra_req_if.sink  req,
  bfra_rsp_if.source rsp,
  bfra_cfg_if.sink  cfg
);
  import bfra_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b00000001,
    S_IDLE   = 8'b00000010,
    S_SEARCH = 8'b00000100,
    S_APPLY  = 8'b00001000,
    S_TAGRD  = 8'b00010000,
    S_FDEC   = 8'b00100000,
    S_MERGE  = 8'b01000000,
    S_DONE   = 8'b10000000
  } state_t;

  state_t            state;
  logic [GW-1:0]     clr_addr;
  logic [CNT_W-1:0]  wait_cnt;
  logic [CNT_W-1:0]  cnt;
  logic [LW-1:0]     init_ln;
  logic [NEED_W-1:0] r_need;
  logic [GW-1:0]     r_key_st;
  logic [LW-1:0]     r_key_ln;
  logic              r_merge;
  logic [1:0]        r_status;
  logic [ADDR_W-1:0] r_addr;
  logic              rsp_v;
  logic [1:0]        rsp_status;
  logic [ADDR_W-1:0] rsp_addr;

  logic [LW-1:0]     tags [TAG_DEPTH];
  logic [LW-1:0]     rdata;
  logic              we;
  logic [GW-1:0]     wa;
  logic [LW-1:0]     wd;
  logic [GW-1:0]     ra;

  ctl_t              ctl;
  chain_stat_t       stat;

  logic [NEED_W-1:0] need_c;
  logic [PG_W-1:0]   pg;
  logic [LW-1:0]     init_ln_c;
  logic [NEED_W-1:0] rem;
  logic              take_all;
  logic [LW-1:0]     blk;
  logic              fdec_fail;
  logic              fdec_ins;
  logic              accept;
  logic              cfg_we;

  assign accept    = req.valid && req.ready;
  assign cfg_we    = cfg.valid && cfg.ready;
  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid      = rsp_v;
  assign rsp.status     = rsp_status;
  assign rsp.block_addr = rsp_addr;

  assign need_c = NEED_W'(({1'b0, req.req_size} + (REQ_W+1)'(GRAN - 1)) >> GRAN_SH) + 1'b1;
  assign pg     = PG_W'(({1'b0, cfg.region_bytes} + (CFG_W+1)'(PAGE_BYTES - 1)) >> PAGE_SH);
  assign init_ln_c = (pg >= MAX_PAGES) ? LW'(MAX_GRAN) : (LW'(pg) << (PAGE_SH - GRAN_SH));
  assign ra     = req.free_addr[ADDR_W-1:GRAN_SH] - 1'b1;

  assign rem       = {1'b0, stat.best.ln} - r_need;
  assign take_all  = (rem <= NEED_W'(1));
  assign blk       = take_all ? stat.best.ln : r_need[LW-1:0];
  assign fdec_fail = (cnt == CNT_W'(MAX_SEGMENTS))
                     && (!r_merge || !(stat.any_touch || stat.key_adj));
  assign fdec_ins  = (r_key_ln != '0) && !fdec_fail;

  always_comb begin
    ctl.op      = OP_HOLD;
    ctl.key_st  = r_key_st;
    ctl.key_ln  = r_key_ln;
    ctl.need    = r_need;
    ctl.sel     = stat.best.idx;
    ctl.init_ln = init_ln;
    case (state)
      S_CLEAR: ctl.op = OP_INIT;
      S_APPLY: begin
        if (stat.best.found) begin
          ctl.op = take_all ? OP_DELETE : OP_SHRINK;
        end
      end
      S_FDEC: begin
        if (fdec_ins) begin
          ctl.op = OP_INSERT;
        end
      end
      S_MERGE: begin
        if (stat.any_touch) begin
          ctl.op = OP_MERGE;
        end
      end
      default: ctl.op = OP_HOLD;
    endcase
  end

  always_comb begin
    we = 1'b0;
    wa = clr_addr;
    wd = '0;
    case (state)
      S_CLEAR: we = 1'b1;
      S_APPLY: begin
        we = stat.best.found;
        wa = stat.best.st;
        wd = blk;
      end
      S_FDEC: begin
        we = fdec_ins;
        wa = r_key_st;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      tags[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= tags[ra];
  end

  bfra_chain u_chain (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .stat (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      wait_cnt <= '0;
      cnt      <= '0;
      init_ln  <= LW'(MAX_GRAN);
      rsp_v    <= 1'b0;
    end else begin
      if (rsp_v && rsp.ready && ((state != S_DONE) || cfg_we)) begin
        rsp_v <= 1'b0;
      end
      if (cfg_we) begin
        init_ln  <= init_ln_c;
        clr_addr <= '0;
        state    <= S_CLEAR;
      end else begin
        case (state)
          S_CLEAR: begin
            cnt      <= CNT_W'(init_ln != '0);
            clr_addr <= clr_addr + 1'b1;
            if (clr_addr == '1) begin
              state <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (accept) begin
              r_addr   <= '0;
              r_need   <= need_c;
              r_merge  <= req.merge_adjacent;
              r_key_st <= ra;
              wait_cnt <= '0;
              if (req.kind == KIND_ALLOC) begin
                state <= S_SEARCH;
              end else if (req.free_addr == '0) begin
                r_status <= ST_OK;
                state    <= S_DONE;
              end else if (req.free_addr[GRAN_SH-1:0] != '0) begin
                r_status <= ST_BADADDR;
                state    <= S_DONE;
              end else begin
                state <= S_TAGRD;
              end
            end
          end
          S_SEARCH: begin
            wait_cnt <= wait_cnt + 1'b1;
            if (wait_cnt == CNT_W'(NCELL - 1)) begin
              state <= S_APPLY;
            end
          end
          S_APPLY: begin
            if (stat.best.found) begin
              r_status <= ST_OK;
              r_addr   <= ADDR_W'({stat.best.st, {GRAN_SH{1'b0}}}) + ADDR_W'(GRAN);
              if (take_all) begin
                cnt <= cnt - 1'b1;
              end
            end else begin
              r_status <= ST_NOSPACE;
            end
            state <= S_DONE;
          end
          S_TAGRD: begin
            r_key_ln <= rdata;
            state    <= S_FDEC;
          end
          S_FDEC: begin
            if (r_key_ln == '0) begin
              r_status <= ST_BADADDR;
              state    <= S_DONE;
            end else if (fdec_fail) begin
              r_status <= ST_NOSPACE;
              state    <= S_DONE;
            end else begin
              r_status <= ST_OK;
              cnt      <= cnt + 1'b1;
              state    <= r_merge ? S_MERGE : S_DONE;
            end
          end
          S_MERGE: begin
            if (stat.any_touch) begin
              cnt <= cnt - 1'b1;
            end else begin
              state <= S_DONE;
            end
          end
          S_DONE: begin
            if (!rsp_v || rsp.ready) begin
              rsp_v      <= 1'b1;
              rsp_status <= r_status;
              rsp_addr   <= r_addr;
              state      <= S_IDLE;
            end
          end
          default: state <= S_CLEAR;
        endcase
      end
    end
  end

  `BFRA_CHK(a_state_onehot, $onehot(state))
  `BFRA_CHK(a_cnt_idle, (state == S_IDLE) |-> (cnt <= CNT_W'(MAX_SEGMENTS)))
  `BFRA_CHK(a_fail_no_addr, (rsp_v && (rsp_status != ST_OK)) |-> (rsp_addr == '0))
  `BFRA_CHK(a_accept_busy, (accept && !cfg.valid) |=> (state != S_IDLE))

endmodule
`default_nettype wire

FILE: bench/best_fit_region_allocator_unit_board.sv
// Scoreboard for the region allocator bench: free-segment predictor and expected responses.
`timescale 1ns / 1ps
class bfra_board;
  int unsigned region_len;
  int unsigned seg_at[$];
  int unsigned seg_sz[$];
  int unsigned tags[int unsigned];
  logic [1:0] exp_status[$];
  logic [15:0] exp_addr[$];
  int unsigned errors;
  int unsigned live_addrs[$];

  function void reset_region(logic [16:0] rb);
    int unsigned l;
    l = ((int'(rb) + bfra_pkg::PAGE_BYTES - 1) / bfra_pkg::PAGE_BYTES) * bfra_pkg::PAGE_BYTES;
    if (l > bfra_pkg::REGION_MAX_BYTES) l = bfra_pkg::REGION_MAX_BYTES;
    region_len = l;
    seg_at.delete();
    seg_sz.delete();
    tags.delete();
    live_addrs.delete();
    if (l != 0) begin
      seg_at.push_back(0);
      seg_sz.push_back(l);
    end
  endfunction

  function void note_request(logic kind, logic [16:0] size, logic [15:0] faddr, logic merge);
    logic [1:0] st;
    logic [15:0] ad;
    int unsigned need, best, start, blk, pos, idx, ln, i;
    int unsigned ts[$];
    int unsigned tl[$];
    bit found;
    st = bfra_pkg::ST_OK;
    ad = 0;
    found = 0;
    best = 0;
    if (kind == bfra_pkg::KIND_ALLOC) begin
      need = ((int'(size) + 7) & ~7) + 8;
      foreach (seg_sz[k])
        if (seg_sz[k] >= need && (!found || seg_sz[k] < seg_sz[best])) begin
          best = k;
          found = 1;
        end
      if (!found) st = bfra_pkg::ST_NOSPACE;
      else begin
        start = seg_at[best];
        if (seg_sz[best] - need <= 8) begin
          blk = seg_sz[best];
          seg_at.delete(best);
          seg_sz.delete(best);
        end else begin
          blk = need;
          seg_at[best] += need;
          seg_sz[best] -= need;
        end
        tags[start / 8] = blk / 8;
        ad = start + 8;
        live_addrs.push_back(start + 8);
      end
    end else if (faddr != 0) begin
      idx = (int'(faddr) - 8) / 8;
      if (faddr < 8 || faddr[2:0] != 0 || !tags.exists(idx)) st = bfra_pkg::ST_BADADDR;
      else begin
        start = faddr - 8;
        ln = tags[idx] * 8;
        ts = seg_at;
        tl = seg_sz;
        pos = 0;
        while (pos < ts.size() && ts[pos] < start) pos++;
        ts.insert(pos, start);
        tl.insert(pos, ln);
        if (merge) begin
          i = 0;
          while (i + 1 < ts.size()) begin
            if (ts[i] + tl[i] == ts[i + 1]) begin
              tl[i] += tl[i + 1];
              ts.delete(i + 1);
              tl.delete(i + 1);
            end else i++;
          end
        end
        if (ts.size() > bfra_pkg::MAX_SEGMENTS) st = bfra_pkg::ST_NOSPACE;
        else begin
          seg_at = ts;
          seg_sz = tl;
          tags.delete(idx);
          foreach (live_addrs[k])
            if (live_addrs[k] == faddr) begin
              live_addrs.delete(k);
              break;
            end
        end
      end
    end
    exp_status.push_back(st);
    exp_addr.push_back(ad);
  endfunction

  task report(string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  task check_response(logic [1:0] st, logic [15:0] ad);
    logic [1:0] es;
    logic [15:0] ea;
    if (exp_status.size() == 0) begin
      report($sformatf("unexpected word status %0d addr %0h", st, ad));
      return;
    end
    es = exp_status.pop_front();
    ea = exp_addr.pop_front();
    if (st !== es) report($sformatf("status %0d, want %0d", st, es));
    if (ad !== ea) report($sformatf("block_addr %0h, want %0h", ad, ea));
  endtask
endclass

FILE: bench/best_fit_region_allocator_unit_test.sv
// Top of the region allocator bench: clock, reset, stimulus, response sink and checks.
`timescale 1ns / 1ps
module best_fit_region_allocator_unit_test;
  import bfra_pkg::*;

  logic clk = 0;
  logic rst = 1;
  bfra_req_if req ();
  bfra_rsp_if rsp ();
  bfra_cfg_if cfg ();
  bfra_board board = new();
  bit hold_rsp = 0;

  best_fit_region_allocator_unit i_dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg));

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    req.valid = 0;
    req.kind = 0;
    req.req_size = 0;
    req.free_addr = 0;
    req.merge_adjacent = 0;
    rsp.ready = 0;
    cfg.valid = 0;
    cfg.region_bytes = 0;
  end

  function int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  always @(posedge clk) begin
    if (rsp.valid && rsp.ready) board.check_response(rsp.status, rsp.block_addr);
  end

  initial begin
    int unsigned g;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_rsp) rsp.ready <= 0;
      else begin
        g = gap_len();
        if (g == 0) rsp.ready <= 1;
        else begin
          rsp.ready <= 0;
          repeat (g) @(posedge clk);
          rsp.ready <= 1;
        end
      end
    end
  end

  task automatic send_request(logic kind, logic [16:0] size, logic [15:0] faddr, logic merge);
    int unsigned g;
    g = gap_len();
    if (g != 0) begin
      req.valid <= 0;
      repeat (g) @(posedge clk);
    end
    req.valid <= 1;
    req.kind <= kind;
    req.req_size <= size;
    req.free_addr <= faddr;
    req.merge_adjacent <= merge;
    do @(posedge clk); while (!req.ready);
    board.note_request(kind, size, faddr, merge);
  endtask

  task automatic write_region(logic [16:0] rb);
    req.valid <= 0;
    while (board.exp_status.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    cfg.valid <= 1;
    cfg.region_bytes <= rb;
    do @(posedge clk); while (!cfg.ready);
    board.reset_region(rb);
    cfg.valid <= 0;
  endtask

  task automatic random_request();
    int unsigned r, n;
    logic [15:0] a;
    r = $urandom_range(0, 99);
    n = board.live_addrs.size();
    if (r < 45) begin
      if ($urandom_range(0, 9) < 8) send_request(KIND_ALLOC, $urandom_range(0, 600), 0, 0);
      else send_request(KIND_ALLOC, $urandom_range(0, 131071), 0, $urandom_range(0, 1));
    end else if (r < 85 && n > 0) begin
      a = board.live_addrs[$urandom_range(0, n - 1)];
      send_request(KIND_FREE, $urandom_range(0, 131071), a, $urandom_range(0, 3) != 0);
    end else begin
      a = $urandom_range(0, 65535);
      if ($urandom_range(0, 1)) a[2:0] = 0;
      send_request(KIND_FREE, $urandom_range(0, 131071), a, $urandom_range(0, 1));
    end
  endtask

  task automatic run_phase(int unsigned count);
    repeat (count) random_request();
  endtask

  initial begin
    logic [16:0] regions[6];
    regions = '{17'd65536, 17'd1, 17'd0, 17'd131071, 17'd12288, 17'd4097};
    board.reset_region(17'd65536);
    repeat (9) @(posedge clk);
    rst <= 0;
    send_request(KIND_ALLOC, 0, 0, 0);
    send_request(KIND_ALLOC, 1, 0, 0);
    send_request(KIND_ALLOC, 17'd65536, 0, 0);
    send_request(KIND_ALLOC, 17'd131071, 0, 1);
    send_request(KIND_FREE, 0, 0, 0);
    send_request(KIND_FREE, 0, 16'd4, 0);
    send_request(KIND_FREE, 0, 16'd13, 1);
    send_request(KIND_FREE, 0, 16'hFFF8, 1);
    send_request(KIND_FREE, 0, 16'hFFFF, 1);
    send_request(KIND_FREE, 0, 16'd8, 0);
    send_request(KIND_FREE, 0, 16'd8, 1);
    send_request(KIND_FREE, 0, 16'd16, 1);
    send_request(KIND_FREE, 0, 16'd16, 1);
    send_request(KIND_ALLOC, 17'd65520, 0, 0);
    send_request(KIND_ALLOC, 17'd8, 0, 0);
    send_request(KIND_FREE, 0, 16'd8, 1);
    write_region(17'd4096);
    for (int k = 0; k < 70; k++) send_request(KIND_ALLOC, 17'd8, 0, 0);
    for (int k = 0; k < 70; k += 2) send_request(KIND_FREE, 0, 16'(8 + 16 * k), 0);
    send_request(KIND_ALLOC, 17'd4000, 0, 0);
    fork
      begin
        hold_rsp = 1;
        repeat (600) @(posedge clk);
        hold_rsp = 0;
      end
      run_phase(8);
    join
    foreach (regions[p]) begin
      write_region(regions[p]);
      run_phase(115);
    end
    req.valid <= 0;
    while (board.exp_status.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.errors == 0) $display("best_fit_region_allocator_unit_test: clean");
    else $display("best_fit_region_allocator_unit_test: errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("best_fit_region_allocator_unit_test: errors");
    $finish;
  end
endmodule
